>>> sv/hashed_block_cache_lru_directory_defines.svh
// Assertion macros for the buffer directory.
// Expects clk and arst_n in the scope of every use.
`ifndef HASHED_BLOCK_CACHE_LRU_DIRECTORY_DEFINES_SVH
`define HASHED_BLOCK_CACHE_LRU_DIRECTORY_DEFINES_SVH

// Same-cycle check, off while reset is held.
`define HBC_CHK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle check, off while reset is held.
`define HBC_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/hbc_pkg.sv
// Shared constants, entry type and bucket hashing for the buffer directory.
// No dependencies.
package hbc_pkg;

	localparam int NUM_BUFS    = 32;
	localparam int NUM_BUCKETS = 13;

	localparam int IDX_W   = $clog2(NUM_BUFS);
	localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int TYPE_W  = 2;
	localparam int DEV_W   = 8;
	localparam int BLK_W   = 32;
	localparam int SLOT_W  = 5;
	localparam int TICK_W  = 32;
	localparam int REFS_W  = 8;
	localparam int STAT_W  = 2;

	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	// request codes
	localparam logic [TYPE_W-1:0] REQ_GET     = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_PIN     = 2'd2;
	localparam logic [TYPE_W-1:0] REQ_UNPIN   = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOBUF = 2'd1;
	localparam logic [STAT_W-1:0] ST_COUNT = 2'd2;

	// block mod buckets: weight each nibble by 16^k mod buckets, then reduce
	localparam int NIBS  = BLK_W / 4;
	localparam int SUM_W = $clog2(NIBS * 15 * NUM_BUCKETS + 1);
	localparam int RED_STEPS = 7;
	localparam int unsigned NIB_WEIGHT [NIBS] = '{
		1 % NUM_BUCKETS, 16 % NUM_BUCKETS, 256 % NUM_BUCKETS, 4096 % NUM_BUCKETS,
		65536 % NUM_BUCKETS, 1048576 % NUM_BUCKETS, 16777216 % NUM_BUCKETS,
		268435456 % NUM_BUCKETS
	};

	typedef struct packed {
		logic [DEV_W-1:0]  dev;
		logic [BLK_W-1:0]  blk;
		logic [BKT_W-1:0]  bkt;
		logic              valid;
		logic [REFS_W-1:0] refs;
		logic [TICK_W-1:0] stamp;
	} entry_t;

	function automatic logic [SUM_W-1:0] bkt_sum(input logic [BLK_W-1:0] blk);
		logic [SUM_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < NIBS; k++) begin
			acc = acc + SUM_W'(blk[4*k +: 4]) * SUM_W'(NIB_WEIGHT[k]);
		end
		return acc;
	endfunction

	// sum stays below 128 times the bucket count, so seven steps finish it
	function automatic logic [BKT_W-1:0] bkt_reduce(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] m;
		r = sum;
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			m = SUM_W'(NUM_BUCKETS) << k;
			if (r >= m) begin
				r = r - m;
			end
		end
		return BKT_W'(r);
	endfunction

endpackage

>>> sv/hbc_if.sv
// Request and response channels of the buffer directory.
// Depends on hbc_pkg for field widths.
interface hbc_req_if import hbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	logic [DEV_W-1:0]  device_id;
	logic [BLK_W-1:0]  block_number;
	logic [SLOT_W-1:0] target_slot;
	logic [TICK_W-1:0] now_tick;

	modport source (output valid, req_type, device_id, block_number, target_slot, now_tick,
		input ready);
	modport sink (input valid, req_type, device_id, block_number, target_slot, now_tick,
		output ready);
endinterface

interface hbc_rsp_if import hbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] granted_slot;
	logic              was_hit;
	logic              needs_read;
	logic [STAT_W-1:0] status;

	modport source (output valid, granted_slot, was_hit, needs_read, status, input ready);
	modport sink (input valid, granted_slot, was_hit, needs_read, status, output ready);
endinterface

>>> sv/hashed_block_cache_lru_directory.sv
// Buffer directory with LRU reuse: a get sweeps the entry memory one entry a cycle,
// looking for a tag hit and the oldest free entry in its bucket and overall.
// A get passes through accept, a sweep that reads every entry, a drain state and
// write-back; release, pin and unpin fetch one entry and write it back. The single
// entry-memory read port, one entry per cycle, paces the sweep. A result waits in
// the output register while the next request is taken; write-back stalls only if
// that register is still full. No clearing pass: per-entry written flags make
// untouched entries read as zero.
// Depends on hbc_pkg, hbc_if and the assertion macro header.
`include "hashed_block_cache_lru_directory_defines.svh"

module hashed_block_cache_lru_directory import hbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hbc_req_if.sink    req,
	hbc_rsp_if.source  rsp
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FETCH = 2'd2;
	localparam logic [1:0] S_WRITE = 2'd3;
	// drain shares no code with fetch: a get passes through S_DRAIN_X after the sweep
	localparam logic [2:0] S_DRAIN_X = 3'd4;

	logic [2:0] state_q;

	// entry memory and its written flags
	entry_t            mem_q [NUM_BUFS];
	logic [NUM_BUFS-1:0] written_q;
	entry_t            rd_raw_s1;
	logic              rd_wr_s1;
	entry_t            rd_ent;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;

	// request
	logic [TYPE_W-1:0] rq_type_q;
	logic [DEV_W-1:0]  rq_dev_q;
	logic [BLK_W-1:0]  rq_blk_q;
	logic [SLOT_W-1:0] rq_slot_q;
	logic [TICK_W-1:0] rq_now_q;
	logic [SUM_W-1:0]  sum_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [IDX_W-1:0]  slot_idx;
	logic              slot_ok;

	// sweep
	logic [IDX_W-1:0]  scan_idx_q;
	logic              chk_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              found_q;
	logic [IDX_W-1:0]  found_idx_q;
	entry_t            found_ent_q;
	logic              bc_ok_q;
	logic [IDX_W-1:0]  bc_idx_q;
	logic [TICK_W-1:0] bc_stamp_q;
	logic              gc_ok_q;
	logic [IDX_W-1:0]  gc_idx_q;
	logic [TICK_W-1:0] gc_stamp_q;
	logic              take_found;
	logic              take_bc;
	logic              take_gc;
	logic              cur_free;

	// write-back and result
	logic              accept;
	logic              out_free;
	logic              wb_fire;
	logic              wr_ok;
	logic [IDX_W-1:0]  wr_idx;
	entry_t            wr_ent;
	logic              mem_we;
	logic [SLOT_W-1:0] res_slot;
	logic              res_hit;
	logic              res_rd;
	logic [STAT_W-1:0] res_status;

	logic              rsp_vld_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	logic              rsp_hit_q;
	logic              rsp_rd_q;
	logic [STAT_W-1:0] rsp_status_q;

	assign req.ready = (state_q == {1'b0, S_IDLE});
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign wb_fire   = (state_q == {1'b0, S_WRITE}) && out_free;
	assign mem_we    = wb_fire && wr_ok;

	assign slot_idx = IDX_W'(rq_slot_q);
	assign slot_ok  = int'(rq_slot_q) < NUM_BUFS;

	assign rd_en   = (state_q == {1'b0, S_SCAN}) || (state_q == {1'b0, S_FETCH});
	assign rd_addr = (state_q == {1'b0, S_SCAN}) ? scan_idx_q : slot_idx;
	assign rd_ent  = rd_wr_s1 ? rd_raw_s1 : '0;

	// compare the entry that came back from memory against the request
	always_comb begin
		cur_free   = (rd_ent.refs == '0);
		take_found = chk_s1 && !found_q && (rd_ent.dev == rq_dev_q) && (rd_ent.blk == rq_blk_q);
		take_gc    = chk_s1 && cur_free && (!gc_ok_q || (rd_ent.stamp < gc_stamp_q));
		take_bc    = chk_s1 && cur_free && (rd_ent.bkt == bkt_q) &&
			(!bc_ok_q || (rd_ent.stamp < bc_stamp_q));
	end

	// decide the write-back and the result
	always_comb begin
		wr_ok      = 1'b0;
		wr_idx     = slot_idx;
		wr_ent     = rd_ent;
		res_slot   = rq_slot_q;
		res_hit    = 1'b0;
		res_rd     = 1'b0;
		res_status = ST_OK;
		unique case (rq_type_q)
			REQ_GET: begin
				res_slot = '0;
				if (found_q) begin
					res_slot = SLOT_W'(found_idx_q);
					res_hit  = 1'b1;
					wr_idx   = found_idx_q;
					wr_ent   = found_ent_q;
					if (found_ent_q.refs == REFS_MAX) begin
						res_status = ST_COUNT;
					end else begin
						wr_ok        = 1'b1;
						res_rd       = !found_ent_q.valid;
						wr_ent.refs  = found_ent_q.refs + REFS_W'(1);
						wr_ent.stamp = rq_now_q;
						wr_ent.valid = 1'b1;
					end
				end else if (bc_ok_q || gc_ok_q) begin
					wr_ok        = 1'b1;
					wr_idx       = bc_ok_q ? bc_idx_q : gc_idx_q;
					res_slot     = SLOT_W'(wr_idx);
					res_rd       = 1'b1;
					wr_ent.dev   = rq_dev_q;
					wr_ent.blk   = rq_blk_q;
					wr_ent.bkt   = bkt_q;
					wr_ent.valid = 1'b1;
					wr_ent.refs  = REFS_W'(1);
					wr_ent.stamp = rq_now_q;
				end else begin
					res_status = ST_NOBUF;
				end
			end
			REQ_PIN: begin
				if (!slot_ok || rd_ent.refs == REFS_MAX) begin
					res_status = ST_COUNT;
				end else begin
					wr_ok       = 1'b1;
					wr_ent.refs = rd_ent.refs + REFS_W'(1);
				end
			end
			REQ_RELEASE, REQ_UNPIN: begin
				if (!slot_ok || rd_ent.refs == '0) begin
					res_status = ST_COUNT;
				end else begin
					wr_ok       = 1'b1;
					wr_ent.refs = rd_ent.refs - REFS_W'(1);
				end
			end
			default: begin
				res_status = ST_COUNT;
			end
		endcase
	end

	// entry memory: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_raw_s1 <= mem_q[rd_addr];
			rd_wr_s1  <= written_q[rd_addr];
		end
		if (mem_we) begin
			mem_q[wr_idx] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= {1'b0, S_IDLE};
			scan_idx_q <= '0;
			chk_s1     <= 1'b0;
			found_q    <= 1'b0;
			bc_ok_q    <= 1'b0;
			gc_ok_q    <= 1'b0;
			rsp_vld_q  <= 1'b0;
			written_q  <= '0;
		end else begin
			chk_s1 <= (state_q == {1'b0, S_SCAN});
			if (wb_fire) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (mem_we) begin
				written_q[wr_idx] <= 1'b1;
			end
			// clear the sweep results on a new request, else collect them
			if (accept) begin
				found_q <= 1'b0;
				bc_ok_q <= 1'b0;
				gc_ok_q <= 1'b0;
			end else begin
				if (take_found) begin
					found_q <= 1'b1;
				end
				if (take_bc) begin
					bc_ok_q <= 1'b1;
				end
				if (take_gc) begin
					gc_ok_q <= 1'b1;
				end
			end
			unique case (state_q)
				{1'b0, S_IDLE}: begin
					if (accept) begin
						scan_idx_q <= '0;
						state_q    <= (req.req_type == REQ_GET) ? {1'b0, S_SCAN} : {1'b0, S_FETCH};
					end
				end
				{1'b0, S_SCAN}: begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
					if (scan_idx_q == IDX_W'(NUM_BUFS - 1)) begin
						state_q <= S_DRAIN_X;
					end
				end
				S_DRAIN_X: begin
					state_q <= {1'b0, S_WRITE};
				end
				{1'b0, S_FETCH}: begin
					state_q <= {1'b0, S_WRITE};
				end
				{1'b0, S_WRITE}: begin
					if (out_free) begin
						state_q <= {1'b0, S_IDLE};
					end
				end
				default: begin
					state_q <= {1'b0, S_IDLE};
				end
			endcase
		end
	end

	// request payload, bucket and sweep candidates
	always_ff @(posedge clk) begin
		if (accept) begin
			rq_type_q <= req.req_type;
			rq_dev_q  <= req.device_id;
			rq_blk_q  <= req.block_number;
			rq_slot_q <= req.target_slot;
			rq_now_q  <= req.now_tick;
			sum_q     <= bkt_sum(req.block_number);
		end
		// ready by the time the first entry comes back
		if (state_q == {1'b0, S_SCAN}) begin
			bkt_q <= bkt_reduce(sum_q);
		end
		idx_s1 <= scan_idx_q;
		if (take_found) begin
			found_idx_q <= idx_s1;
			found_ent_q <= rd_ent;
		end
		if (take_bc) begin
			bc_idx_q   <= idx_s1;
			bc_stamp_q <= rd_ent.stamp;
		end
		if (take_gc) begin
			gc_idx_q   <= idx_s1;
			gc_stamp_q <= rd_ent.stamp;
		end
		if (wb_fire) begin
			rsp_slot_q   <= res_slot;
			rsp_hit_q    <= res_hit;
			rsp_rd_q     <= res_rd;
			rsp_status_q <= res_status;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.granted_slot = rsp_slot_q;
	assign rsp.was_hit      = rsp_hit_q;
	assign rsp.needs_read   = rsp_rd_q;
	assign rsp.status       = rsp_status_q;

	`HBC_CHK(a_rsp_from_wb, $rose(rsp.valid), $past(state_q == {1'b0, S_WRITE}), "response not from write-back")
	`HBC_NEXT(a_we_ends_item, mem_we, (state_q == {1'b0, S_IDLE}) && rsp_vld_q, "write-back did not finish item")
	`HBC_CHK(a_nobuf_shape, rsp.valid && (rsp.status == ST_NOBUF), (rsp.granted_slot == '0) && !rsp.was_hit && !rsp.needs_read, "bad no-buffer result")
	`HBC_CHK(a_drain_is_get, state_q == S_DRAIN_X, rq_type_q == REQ_GET, "sweep on a non-get request")

endmodule
